@@ sv/dat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dynamic array table package
// Shared types, codes and port widths for the dynamic array table block.
// ----------------------------------------------------------------------------
package dat_pkg;

	localparam int IN_W  = 48;
	localparam int OUT_W = 72;
	localparam int CFG_W = 11;
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int CNT_OUT_W = 11;
	localparam int CAP_OUT_W = 12;
	localparam int OUT_PAD_W = OUT_W - (2 + VAL_W + 1 + IDX_W + CNT_OUT_W + CAP_OUT_W);

	typedef enum logic [2:0] {
		ACT_APPEND = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_EDIT   = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_GET    = 3'd4,
		ACT_FIND   = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_INDEX  = 2'd1,
		ST_STORE_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_DRAIN,
		S_PUT,
		S_SHRINK,
		S_GET,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    scan_start;
		logic    scan_step;
		logic    wr_val;
		logic    rd_idx;
		logic    get_cap;
		logic    grow;
		logic    cnt_inc;
		logic    del_commit;
		logic    set_st;
		status_t st;
		logic    load_out;
	} dat_cmd_t;

	typedef struct packed {
		act_t act;
		logic idx_gt;
		logic idx_ge;
		logic del_no_shift;
		logic full;
		logic cnt_zero;
		logic scan_last;
		logic match_now;
		logic out_busy;
	} dat_stat_t;

endpackage

@@ sv/dynamic_array_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dynamic array table
// Ordered array of signed 32-bit values with growing and shrinking capacity.
// ----------------------------------------------------------------------------
// Every input transaction yields exactly one output transaction. Append, edit,
// get, rejected actions and unused codes do not walk the store. Insert, delete
// and find, when they must move or search entries, walk the element store one
// entry per cycle through its single read port. One action is worked on at a
// time; a new input transaction is taken while the previous result waits in
// the output register. Store entries hold no reset value and need no
// clearing pass after reset. Writing cfg_wdata sets the capacity and empties
// the array; it is to be done by the user only while the block is idle, and
// the block itself does not enforce it.
module dynamic_array_table_top #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [dat_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// Fields from bit 0: action[2:0], index[12:3], value[44:13], zero pad.
	input  logic [dat_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// Fields from bit 0: status[1:0], read_value[33:2], found[34],
	// position[44:35], count_out[55:45], capacity_out[67:56], zero pad.
	output logic [dat_pkg::OUT_W-1:0] m_tdata
);

	dat_pkg::dat_cmd_t  cmd;
	dat_pkg::dat_stat_t stat;

	dat_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (cmd),
		.stat    (stat)
	);

	dat_dpath #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ sv/dat_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/dat_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dynamic array table controller
// Sequences each action through decision, entry walk, commit and result.
// ----------------------------------------------------------------------------
module dat_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output dat_pkg::dat_cmd_t  cmd,
	input  dat_pkg::dat_stat_t stat
);

	dat_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.st   = dat_pkg::ST_OK;
		s_tready = 1'b0;
		unique case (state_q)
			dat_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = dat_pkg::S_DECIDE;
				end
			end
			dat_pkg::S_DECIDE: begin
				state_d = dat_pkg::S_DONE;
				unique case (stat.act)
					dat_pkg::ACT_APPEND: begin
						if (stat.full) begin
							cmd.set_st = 1'b1;
							cmd.st     = dat_pkg::ST_STORE_FULL;
						end else begin
							cmd.wr_val  = 1'b1;
							cmd.grow    = 1'b1;
							cmd.cnt_inc = 1'b1;
						end
					end
					dat_pkg::ACT_INSERT: begin
						priority if (stat.idx_gt) begin
							cmd.set_st = 1'b1;
							cmd.st     = dat_pkg::ST_BAD_INDEX;
						end else if (stat.full) begin
							cmd.set_st = 1'b1;
							cmd.st     = dat_pkg::ST_STORE_FULL;
						end else if (stat.idx_ge) begin
							cmd.grow = 1'b1;
							state_d  = dat_pkg::S_PUT;
						end else begin
							cmd.grow       = 1'b1;
							cmd.scan_start = 1'b1;
							state_d        = dat_pkg::S_SCAN;
						end
					end
					dat_pkg::ACT_EDIT: begin
						if (stat.idx_ge) begin
							cmd.set_st = 1'b1;
							cmd.st     = dat_pkg::ST_BAD_INDEX;
						end else begin
							cmd.wr_val = 1'b1;
						end
					end
					dat_pkg::ACT_DELETE: begin
						priority if (stat.idx_ge) begin
							cmd.set_st = 1'b1;
							cmd.st     = dat_pkg::ST_BAD_INDEX;
						end else if (stat.del_no_shift) begin
							state_d = dat_pkg::S_SHRINK;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = dat_pkg::S_SCAN;
						end
					end
					dat_pkg::ACT_GET: begin
						if (stat.idx_ge) begin
							cmd.set_st = 1'b1;
							cmd.st     = dat_pkg::ST_BAD_INDEX;
						end else begin
							cmd.rd_idx = 1'b1;
							state_d    = dat_pkg::S_GET;
						end
					end
					dat_pkg::ACT_FIND: begin
						if (!stat.cnt_zero) begin
							cmd.scan_start = 1'b1;
							state_d        = dat_pkg::S_SCAN;
						end
					end
					default: begin
						state_d = dat_pkg::S_DONE;
					end
				endcase
			end
			dat_pkg::S_SCAN: begin
				if (stat.match_now) begin
					state_d = dat_pkg::S_DONE;
				end else begin
					cmd.scan_step = 1'b1;
					if (stat.scan_last) begin
						state_d = dat_pkg::S_DRAIN;
					end
				end
			end
			dat_pkg::S_DRAIN: begin
				priority case (stat.act)
					dat_pkg::ACT_INSERT: state_d = dat_pkg::S_PUT;
					dat_pkg::ACT_DELETE: state_d = dat_pkg::S_SHRINK;
					default:             state_d = dat_pkg::S_DONE;
				endcase
			end
			dat_pkg::S_PUT: begin
				cmd.wr_val  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = dat_pkg::S_DONE;
			end
			dat_pkg::S_SHRINK: begin
				cmd.del_commit = 1'b1;
				state_d        = dat_pkg::S_DONE;
			end
			dat_pkg::S_GET: begin
				cmd.get_cap = 1'b1;
				state_d     = dat_pkg::S_DONE;
			end
			dat_pkg::S_DONE: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = dat_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dat_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ sv/dat_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dynamic array table datapath
// Element store, count and capacity, walk pointer, result and output register.
// ----------------------------------------------------------------------------
module dat_dpath #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dat_pkg::dat_cmd_t         cmd,
	output dat_pkg::dat_stat_t        stat,
	input  logic                      cfg_we,
	input  logic [dat_pkg::CFG_W-1:0] cfg_wdata,
	input  logic [dat_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [dat_pkg::OUT_W-1:0] m_tdata
);

	localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int KW   = $clog2(2 * MAX_ENTRIES + 1);
	localparam int CMPW = ((CW > dat_pkg::IDX_W) ? CW : dat_pkg::IDX_W) + 1;

	dat_pkg::act_t             act_q;
	logic [dat_pkg::IDX_W-1:0] idx_q;
	logic [dat_pkg::VAL_W-1:0] val_q;
	logic [CW-1:0]             cnt_q;
	logic [KW-1:0]             cap_q;
	logic [AW-1:0]             ptr_q;
	logic [AW-1:0]             end_q;
	logic                      pend_q;
	logic [AW-1:0]             paddr_q;
	dat_pkg::status_t          res_st_q;
	logic [dat_pkg::VAL_W-1:0] res_rd_q;
	logic                      res_found_q;
	logic [dat_pkg::IDX_W-1:0] res_pos_q;
	logic                      m_tvalid_q;
	logic [dat_pkg::OUT_W-1:0] m_tdata_q;

	logic [CMPW-1:0]           idx_w;
	logic [CMPW-1:0]           cnt_w;
	logic [CW-1:0]             cnt_dec;
	logic [31:0]               cfg_ext;
	logic [31:0]               cap_clamp;
	logic                      shift_wr;
	logic                      match_now;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [dat_pkg::VAL_W-1:0] ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic [dat_pkg::VAL_W-1:0] ram_rdata;

	dat_ram #(
		.WIDTH(dat_pkg::VAL_W),
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		idx_w     = CMPW'(idx_q);
		cnt_w     = CMPW'(cnt_q);
		cnt_dec   = cnt_q - CW'(1);
		match_now = pend_q && (act_q == dat_pkg::ACT_FIND) && (ram_rdata == val_q);
		shift_wr  = pend_q && ((act_q == dat_pkg::ACT_INSERT) ||
			(act_q == dat_pkg::ACT_DELETE));

		cfg_ext = 32'(cfg_wdata);
		priority if (cfg_ext == 32'd0) begin
			cap_clamp = 32'd1;
		end else if (cfg_ext > 32'(MAX_ENTRIES)) begin
			cap_clamp = 32'(MAX_ENTRIES);
		end else begin
			cap_clamp = cfg_ext;
		end

		ram_we    = shift_wr || cmd.wr_val;
		ram_wdata = shift_wr ? ram_rdata : val_q;
		priority if (shift_wr) begin
			ram_waddr = (act_q == dat_pkg::ACT_INSERT) ? paddr_q + AW'(1) : paddr_q - AW'(1);
		end else if (act_q == dat_pkg::ACT_APPEND) begin
			ram_waddr = cnt_q[AW-1:0];
		end else begin
			ram_waddr = AW'(idx_q);
		end
		ram_raddr = cmd.rd_idx ? AW'(idx_q) : ptr_q;

		stat.act          = act_q;
		stat.idx_gt       = idx_w > cnt_w;
		stat.idx_ge       = idx_w >= cnt_w;
		stat.del_no_shift = (idx_w + CMPW'(1)) >= cnt_w;
		stat.full         = cnt_q == CW'(MAX_ENTRIES);
		stat.cnt_zero     = cnt_q == '0;
		stat.scan_last    = ptr_q == end_q;
		stat.match_now    = match_now;
		stat.out_busy     = m_tvalid_q && !m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			cap_q      <= KW'(2);
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			pend_q <= cmd.scan_step;
			if (cfg_we) begin
				cnt_q <= '0;
				cap_q <= KW'(cap_clamp);
			end else begin
				if (cmd.grow && (KW'(cnt_q) >= cap_q)) begin
					cap_q <= cap_q << 1;
				end
				if (cmd.cnt_inc) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (cmd.del_commit) begin
					cnt_q <= cnt_dec;
					if ((KW'(cnt_dec) <= (cap_q >> 1)) && (cap_q > KW'(1))) begin
						cap_q <= cap_q >> 1;
					end
				end
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q       <= dat_pkg::act_t'(s_tdata[2:0]);
			idx_q       <= s_tdata[12:3];
			val_q       <= s_tdata[44:13];
			res_st_q    <= dat_pkg::ST_OK;
			res_rd_q    <= '0;
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end
		if (cmd.set_st) begin
			res_st_q <= cmd.st;
		end
		if (cmd.get_cap) begin
			res_rd_q <= ram_rdata;
		end
		if (match_now && !res_found_q) begin
			res_found_q <= 1'b1;
			res_pos_q   <= dat_pkg::IDX_W'(paddr_q);
		end
		if (cmd.scan_start) begin
			unique case (act_q)
				dat_pkg::ACT_INSERT: begin
					ptr_q <= AW'(cnt_dec);
					end_q <= AW'(idx_q);
				end
				dat_pkg::ACT_DELETE: begin
					ptr_q <= AW'(idx_q) + AW'(1);
					end_q <= AW'(cnt_dec);
				end
				default: begin
					ptr_q <= '0;
					end_q <= AW'(cnt_dec);
				end
			endcase
		end else if (cmd.scan_step) begin
			ptr_q <= (act_q == dat_pkg::ACT_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
		end
		if (cmd.scan_step) begin
			paddr_q <= ptr_q;
		end
		if (cmd.load_out) begin
			m_tdata_q <= {{dat_pkg::OUT_PAD_W{1'b0}}, dat_pkg::CAP_OUT_W'(cap_q),
				dat_pkg::CNT_OUT_W'(cnt_q), res_pos_q, res_found_q, res_rd_q, res_st_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ sv/dat_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dynamic array table checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dat_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [dat_pkg::OUT_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Output transaction changed while stalled.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("Output status holds an unused code.");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> m_tdata[1:0] == 2'd0)
		else $error("Find hit reported with a nonzero status.");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[33:2] != 32'd0) |-> m_tdata[1:0] == 2'd0)
		else $error("Read value reported with a nonzero status.");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> {1'b0, m_tdata[55:45]} <= m_tdata[67:56])
		else $error("Element count exceeds capacity.");

endmodule

bind dynamic_array_table_top dat_checker u_dat_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

@@ tb/dat_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dynamic array table checker
// Watches the configuration port and both streams of the dynamic array table.
// It keeps its own copy of the array, count and capacity, works out the
// result of every accepted input transaction, and compares each output
// transaction field by field with the oldest result still owed.
// ----------------------------------------------------------------------------
module dat_table_checker
	import dat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	output int               mismatches,
	output int               outstanding,
	output int               results_seen
);

	localparam int STORE_DEPTH = 1024;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] read_value;
		logic             found;
		logic [IDX_W-1:0] position;
		logic [10:0]      count;
		logic [11:0]      capacity;
	} table_result_t;

	logic [VAL_W-1:0] arr_mem [STORE_DEPTH];
	int               arr_count;
	int               arr_cap;
	table_result_t    owed_results [$];

	function automatic int clamp_capacity(input logic [CFG_W-1:0] v);
		if (v == 0) begin
			return 1;
		end
		if (v > STORE_DEPTH) begin
			return STORE_DEPTH;
		end
		return int'(v);
	endfunction

	function automatic table_result_t apply_action(input act_t act, input int idx,
			input logic [VAL_W-1:0] val);
		table_result_t r;
		int            i;
		logic          hit;
		r = '0;
		r.status = ST_OK;
		hit = 1'b0;
		case (act)
			ACT_APPEND: begin
				if (arr_count >= STORE_DEPTH) begin
					r.status = ST_STORE_FULL;
				end else begin
					if (arr_count >= arr_cap) begin
						arr_cap = 2 * arr_cap;
					end
					arr_mem[arr_count] = val;
					arr_count++;
				end
			end
			ACT_INSERT: begin
				if (idx > arr_count) begin
					r.status = ST_BAD_INDEX;
				end else if (arr_count >= STORE_DEPTH) begin
					r.status = ST_STORE_FULL;
				end else begin
					if (arr_count >= arr_cap) begin
						arr_cap = 2 * arr_cap;
					end
					for (i = arr_count; i > idx; i--) begin
						arr_mem[i] = arr_mem[i - 1];
					end
					arr_mem[idx] = val;
					arr_count++;
				end
			end
			ACT_EDIT: begin
				if (idx >= arr_count) begin
					r.status = ST_BAD_INDEX;
				end else begin
					arr_mem[idx] = val;
				end
			end
			ACT_DELETE: begin
				if (idx >= arr_count) begin
					r.status = ST_BAD_INDEX;
				end else begin
					for (i = idx; i + 1 < arr_count; i++) begin
						arr_mem[i] = arr_mem[i + 1];
					end
					arr_count--;
					if (arr_count <= arr_cap / 2 && arr_cap > 1) begin
						arr_cap = arr_cap / 2;
					end
				end
			end
			ACT_GET: begin
				if (idx >= arr_count) begin
					r.status = ST_BAD_INDEX;
				end else begin
					r.read_value = arr_mem[idx];
				end
			end
			ACT_FIND: begin
				for (i = 0; i < arr_count && !hit; i++) begin
					if (arr_mem[i] == val) begin
						hit = 1'b1;
						r.found = 1'b1;
						r.position = 10'(i);
					end
				end
			end
			default: begin
			end
		endcase
		r.count = 11'(arr_count);
		r.capacity = 12'(arr_cap);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t ns] result %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	task automatic check_result(input logic [OUT_W-1:0] d);
		table_result_t want;
		if (owed_results.size() == 0) begin
			report_mismatch("output transaction with no input transaction behind it");
		end else begin
			want = owed_results.pop_front();
			if (d[1:0] !== want.status)
				report_mismatch($sformatf("status is %0d, expected %0d", d[1:0], want.status));
			if (d[33:2] !== want.read_value)
				report_mismatch($sformatf("read_value is %08h, expected %08h",
					d[33:2], want.read_value));
			if (d[34] !== want.found)
				report_mismatch($sformatf("found is %0b, expected %0b", d[34], want.found));
			if (d[44:35] !== want.position)
				report_mismatch($sformatf("position is %0d, expected %0d",
					d[44:35], want.position));
			if (d[55:45] !== want.count)
				report_mismatch($sformatf("count_out is %0d, expected %0d",
					d[55:45], want.count));
			if (d[67:56] !== want.capacity)
				report_mismatch($sformatf("capacity_out is %0d, expected %0d",
					d[67:56], want.capacity));
		end
		results_seen++;
	endtask

	// A result leaving in the same cycle as a new input belongs to an older
	// transaction, so the comparison is made before the new prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arr_count = 0;
			arr_cap = 2;
			owed_results.delete();
			mismatches = 0;
			results_seen = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				arr_cap = clamp_capacity(cfg_wdata);
				arr_count = 0;
			end
			if (m_tvalid && m_tready) begin
				check_result(m_tdata);
			end
			if (s_tvalid && s_tready) begin
				owed_results.push_back(apply_action(act_t'(s_tdata[2:0]),
					int'(s_tdata[12:3]), s_tdata[44:13]));
			end
			outstanding = owed_results.size();
		end
	end

endmodule

@@ tb/tb_dynamic_array_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dynamic array table testbench
// Drives directed and random actions into the dynamic array table under
// several capacity settings, with bursty input and a stalling output side.
// A separate checker predicts and compares every result; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_dynamic_array_table_top;
	import dat_pkg::*;

	localparam int          STORE_DEPTH  = 1024;
	localparam int          IDLE_LIMIT   = 8000;
	localparam int          SETTLE_TICKS = 8;
	localparam int          PHASE_ITEMS  = 93;
	localparam logic [2:0]  ACT_RSVD_6   = 3'd6;
	localparam logic [2:0]  ACT_RSVD_7   = 3'd7;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	int mismatches;
	int outstanding;
	int results_seen;

	int          shadow_len;
	int          burst_left;
	int          items_sent;
	int          settings_used;
	int          idle_cycles;
	int          rx_tick;
	int          rx_mode;
	logic [31:0] key_pool [8];

	dynamic_array_table_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	dat_table_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver moves between always ready, random stalls and a fixed stall
	// pattern, with the mode picked at random.
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 64 == 0) begin
			rx_mode <= $urandom_range(0, 2);
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= (rx_tick % 7 < 3);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles.", IDLE_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(input logic [2:0] act, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - VAL_W - IDX_W - 3){1'b0}}, val, idx, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		items_sent++;
		case (act)
			ACT_APPEND: if (shadow_len < STORE_DEPTH) shadow_len++;
			ACT_INSERT: if (idx <= shadow_len && shadow_len < STORE_DEPTH) shadow_len++;
			ACT_DELETE: if (idx < shadow_len) shadow_len--;
			default: begin
			end
		endcase
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] cap);
		@(negedge clk);
		cfg_wdata <= cap;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_len = 0;
		settings_used++;
	endtask

	task automatic random_item(input int target);
		int               r;
		int               hi;
		logic [2:0]       act;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] val;
		r = $urandom_range(0, 99);
		if (r < 22) act = ACT_APPEND;
		else if (r < 36) act = ACT_INSERT;
		else if (r < 48) act = ACT_EDIT;
		else if (r < 66) act = ACT_DELETE;
		else if (r < 78) act = ACT_GET;
		else if (r < 94) act = ACT_FIND;
		else if (r < 97) act = ACT_RSVD_6;
		else act = ACT_RSVD_7;
		if (shadow_len > target && $urandom_range(0, 1) == 1) begin
			act = ACT_DELETE;
		end else if (shadow_len < target / 2 && $urandom_range(0, 1) == 1) begin
			act = ACT_APPEND;
		end
		hi = (act == ACT_INSERT) ? shadow_len : shadow_len - 1;
		r = $urandom_range(0, 19);
		if (r < 15 && hi >= 0) idx = 10'($urandom_range(0, hi));
		else if (r < 18) idx = 10'(shadow_len);
		else idx = 10'($urandom_range(0, STORE_DEPTH - 1));
		if ($urandom_range(0, 1) == 1) val = key_pool[$urandom_range(0, 7)];
		else val = $urandom;
		send_item(act, idx, val);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] cap, input int target);
		drain();
		write_capacity(cap);
		repeat (PHASE_ITEMS) random_item(target);
	endtask

	initial begin
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int k = 4; k < 8; k++) key_pool[k] = $urandom;
		shadow_len = 0;
		burst_left = 0;
		items_sent = 0;
		settings_used = 1;
		rx_tick = 0;
		rx_mode = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Empty array, bad indexes, capacity growth and shrink from reset.
		send_item(ACT_GET, '0, '0);
		send_item(ACT_DELETE, '0, '0);
		send_item(ACT_EDIT, '0, 32'h1234_5678);
		send_item(ACT_FIND, '0, '0);
		send_item(ACT_INSERT, 10'd1, 32'h1);
		send_item(ACT_INSERT, '0, 32'h8000_0000);
		send_item(ACT_APPEND, 10'd1023, 32'h7FFF_FFFF);
		send_item(ACT_APPEND, '0, '0);
		send_item(ACT_INSERT, 10'd3, 32'hFFFF_FFFF);
		send_item(ACT_INSERT, '0, 32'd5);
		send_item(ACT_EDIT, 10'd4, 32'h7FFF_FFFF);
		send_item(ACT_FIND, '0, 32'h7FFF_FFFF);
		send_item(ACT_FIND, '0, 32'd12345);
		send_item(ACT_GET, 10'd4, '0);
		send_item(ACT_GET, 10'd5, '0);
		send_item(ACT_RSVD_6, '0, '0);
		send_item(ACT_RSVD_7, 10'd1023, 32'hFFFF_FFFF);
		send_item(ACT_DELETE, '0, '0);
		send_item(ACT_DELETE, 10'd3, '0);
		send_item(ACT_DELETE, 10'd1023, '0);
		send_item(ACT_EDIT, 10'd1023, '1);
		send_item(ACT_DELETE, '0, '0);
		send_item(ACT_DELETE, '0, '0);
		send_item(ACT_DELETE, '0, '0);

		run_phase(11'd2047, 24);
		run_phase(11'd1, 6);
		run_phase(11'd3, 12);
		run_phase(11'($urandom_range(4, 64)), 40);
		run_phase(11'($urandom_range(65, 1023)), 30);
		run_phase(11'd1024, 16);
		drain();

		$display("Sent %0d input transactions under %0d capacity settings.",
			items_sent, settings_used);
		$display("Checked %0d output transactions against the prediction.", results_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/dat_pkg.sv
sv/dat_ram.sv
sv/dat_ctrl.sv
sv/dat_dpath.sv
sv/dynamic_array_table_top.sv
sv/dat_checker.sv
tb/dat_table_checker.sv
tb/tb_dynamic_array_table_top.sv
